// ===== rtl/core/kvt_pkg.sv =====
// ----------------------------------------------------------------------------
// kvt_pkg: shared types and codes for the key/value table
// Request and response payloads, action and status codes, controller states,
// and the byte mask helper used to clear bytes past a length.
// ----------------------------------------------------------------------------
package kvt_pkg;

    typedef enum logic [1:0] {
        ACT_PUT    = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_CAS    = 2'd2,
        ACT_GET    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_MISMATCH  = 3'd2,
        ST_FULL      = 3'd3,
        ST_MALFORMED = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_RESULT
    } state_t;

    typedef struct packed {
        action_t     action;
        logic [63:0] key;
        logic [3:0]  key_len;
        logic [63:0] new_value;
        logic [3:0]  value_len;
        logic [63:0] expected_value;
        logic [3:0]  expected_len;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [63:0] read_value;
        logic [3:0]  read_len;
        logic [6:0]  entry_count;
    } rsp_t;

    localparam logic [6:0] LIMIT_RESET = 7'd64;

    // Keep the low len bytes, clear the rest.
    function automatic logic [63:0] byte_mask(input logic [3:0] len);
        logic [63:0] m;
        for (int i = 0; i < 8; i++)
        begin
            m[8*i +: 8] = (4'(i) < len) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

// ===== rtl/core/kvt_slot_ram.sv =====
// ----------------------------------------------------------------------------
// kvt_slot_ram: slot memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module kvt_slot_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 137,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/key_value_table_cas.sv =====
// Each request passes through the idle, scan, execute and result states: the scan issues
// one read per active slot (min(table_limit, ENTRIES)) and drains the last read, execute
// writes back at most one slot, and result loads the response register once it is free.
// A malformed request skips the scan. One request is in flight at a time and the next is
// taken in the idle cycle after the response loads.
// Reset: rst_n clears control state, then a clearing pass frees every slot.
// ----------------------------------------------------------------------------
// key_value_table_cas: associative key/value table with compare-and-swap
// Put, delete, compare-and-swap and get over a table of byte-key slots held
// in one synchronous memory. Each well-formed request scans the active slots for a key
// match and the lowest free slot, then writes back at most one slot.
// req_stall stays high during the clearing pass (config writes still taken).
// ----------------------------------------------------------------------------
module key_value_table_cas #(
    parameter int ENTRIES     = 64,
    parameter int KEY_BYTES   = 8,
    parameter int VALUE_BYTES = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    // request channel
    input  logic           req_valid,
    output logic           req_stall,
    input  kvt_pkg::req_t  req,
    // response channel
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output kvt_pkg::rsp_t  rsp,
    // configuration: table_limit
    input  logic           cfg_we,
    input  logic [6:0]     cfg_wdata
);

    localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IDX_W  = ADDR_W + 1;           // can hold ENTRIES itself
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (IDX_W > 7) ? IDX_W : 7;
    localparam int KEY_W  = KEY_BYTES * 8;
    localparam int VAL_W  = VALUE_BYTES * 8;

    // One slot as stored in memory.
    typedef struct packed {
        logic             used;
        logic [3:0]       key_len;
        logic [KEY_W-1:0] key;
        logic [3:0]       value_len;
        logic [VAL_W-1:0] value;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    kvt_pkg::state_t state_reg, state_next;

    logic [6:0]        limit_reg, limit_next;
    logic [CNT_W-1:0]  used_count_reg, used_count_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;          // clear sweep and scan issue
    logic              rd_pend_reg, rd_pend_next;  // read issued last cycle
    logic [ADDR_W-1:0] rd_idx_reg, rd_idx_next;
    logic              hit_found_reg, hit_found_next;
    logic              free_found_reg, free_found_next;
    logic              malformed_reg, malformed_next;
    logic              rsp_valid_reg, rsp_valid_next;

    // payload registers, no reset
    kvt_pkg::req_t     req_reg, req_next;
    logic [ADDR_W-1:0] hit_idx_reg, hit_idx_next;
    logic [3:0]        hit_vlen_reg, hit_vlen_next;
    logic [VAL_W-1:0]  hit_value_reg, hit_value_next;
    logic [ADDR_W-1:0] free_idx_reg, free_idx_next;
    kvt_pkg::status_t  res_status_reg, res_status_next;
    logic [63:0]       res_value_reg, res_value_next;
    logic [3:0]        res_len_reg, res_len_next;
    kvt_pkg::rsp_t     rsp_reg, rsp_next;

    // memory ports
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    slot_t             mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [SLOT_W-1:0] mem_rdata;
    slot_t             rd_slot;

    kvt_slot_ram #(
        .DEPTH  (ENTRIES),
        .WIDTH  (SLOT_W),
        .ADDR_W (ADDR_W)
    ) u_slot_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_slot = slot_t'(mem_rdata);

    // ------------------------------------------------------------------
    // Active limit: table_limit clipped to ENTRIES
    // ------------------------------------------------------------------
    logic [CMP_W-1:0] limit_ext;
    logic [IDX_W-1:0] active_lim;

    assign limit_ext  = CMP_W'(limit_reg);
    assign active_lim = (limit_ext < CMP_W'(ENTRIES)) ? IDX_W'(limit_ext)
                                                      : IDX_W'(ENTRIES);

    // ------------------------------------------------------------------
    // Incoming request: mask bytes past each length, check lengths
    // ------------------------------------------------------------------
    kvt_pkg::req_t req_masked;
    logic          req_bad;

    always_comb
    begin
        req_masked                = req;
        req_masked.key            = req.key & kvt_pkg::byte_mask(req.key_len);
        req_masked.new_value      = req.new_value & kvt_pkg::byte_mask(req.value_len);
        req_masked.expected_value = req.expected_value
                                    & kvt_pkg::byte_mask(req.expected_len);

        req_bad = (req.key_len == 4'd0) || (req.key_len > 4'(KEY_BYTES))
                  || ((req.action inside {kvt_pkg::ACT_PUT, kvt_pkg::ACT_CAS})
                      && (req.value_len > 4'(VALUE_BYTES)))
                  || ((req.action == kvt_pkg::ACT_CAS)
                      && (req.expected_len > 4'(VALUE_BYTES)));
    end

    // ------------------------------------------------------------------
    // Slot compare on the word returned by the memory
    // ------------------------------------------------------------------
    logic key_match;

    assign key_match = rd_slot.used && (rd_slot.key_len == req_reg.key_len)
                       && (rd_slot.key == req_reg.key[KEY_W-1:0]);

    // compare-and-swap: an absent key reads as an empty value
    logic [3:0]  cur_len;
    logic [63:0] cur_value;
    logic        cas_ok;

    assign cur_len   = hit_found_reg ? hit_vlen_reg : 4'd0;
    assign cur_value = hit_found_reg ? 64'(hit_value_reg) : 64'd0;
    assign cas_ok    = (cur_len == req_reg.expected_len)
                       && (cur_value == req_reg.expected_value);

    // ------------------------------------------------------------------
    // Sequencer: next state, memory access and result
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        limit_next      = cfg_we ? cfg_wdata : limit_reg;
        used_count_next = used_count_reg;
        idx_next        = idx_reg;
        rd_pend_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        hit_found_next  = hit_found_reg;
        free_found_next = free_found_reg;
        malformed_next  = malformed_reg;
        req_next        = req_reg;
        hit_idx_next    = hit_idx_reg;
        hit_vlen_next   = hit_vlen_reg;
        hit_value_next  = hit_value_reg;
        free_idx_next   = free_idx_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_len_next    = res_len_reg;
        rsp_next        = rsp_reg;

        // drop the response once the sink takes it
        rsp_valid_next  = rsp_valid_reg && rsp_stall;

        mem_we    = 1'b0;
        mem_waddr = idx_reg[ADDR_W-1:0];
        mem_wdata = '0;
        mem_raddr = idx_reg[ADDR_W-1:0];

        req_stall = (state_reg != kvt_pkg::S_IDLE);

        case (state_reg)
            kvt_pkg::S_CLEAR:
            begin
                // free one slot per cycle
                mem_we    = 1'b1;
                mem_waddr = idx_reg[ADDR_W-1:0];
                mem_wdata = '0;
                if (idx_reg == IDX_W'(ENTRIES - 1))
                begin
                    state_next = kvt_pkg::S_IDLE;
                end
                idx_next = idx_reg + IDX_W'(1);
            end

            kvt_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next        = req_masked;
                    malformed_next  = req_bad;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    idx_next        = '0;
                    state_next      = req_bad ? kvt_pkg::S_EXEC : kvt_pkg::S_SCAN;
                end
            end

            kvt_pkg::S_SCAN:
            begin
                // issue one read per cycle over the active slots
                if (idx_reg < active_lim)
                begin
                    mem_raddr    = idx_reg[ADDR_W-1:0];
                    rd_pend_next = 1'b1;
                    rd_idx_next  = idx_reg[ADDR_W-1:0];
                    idx_next     = idx_reg + IDX_W'(1);
                end
                else if (!rd_pend_reg)
                begin
                    state_next = kvt_pkg::S_EXEC;
                end

                // check the slot read in the previous cycle; keep the lowest
                if (rd_pend_reg)
                begin
                    if (!hit_found_reg && key_match)
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = rd_idx_reg;
                        hit_vlen_next  = rd_slot.value_len;
                        hit_value_next = rd_slot.value;
                    end
                    if (!free_found_reg && !rd_slot.used)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = rd_idx_reg;
                    end
                end
            end

            kvt_pkg::S_EXEC:
            begin
                res_status_next     = kvt_pkg::ST_OK;
                res_value_next      = 64'd0;
                res_len_next        = 4'd0;
                mem_wdata.used      = 1'b1;
                mem_wdata.key_len   = req_reg.key_len;
                mem_wdata.key       = req_reg.key[KEY_W-1:0];
                mem_wdata.value_len = req_reg.value_len;
                mem_wdata.value     = req_reg.new_value[VAL_W-1:0];
                state_next          = kvt_pkg::S_RESULT;

                if (malformed_reg)
                begin
                    res_status_next = kvt_pkg::ST_MALFORMED;
                end
                else
                begin
                    case (req_reg.action)
                        kvt_pkg::ACT_PUT, kvt_pkg::ACT_CAS:
                        begin
                            if ((req_reg.action == kvt_pkg::ACT_CAS) && !cas_ok)
                            begin
                                res_status_next = kvt_pkg::ST_MISMATCH;
                            end
                            else if (hit_found_reg)
                            begin
                                // overwrite the value in place
                                mem_we    = 1'b1;
                                mem_waddr = hit_idx_reg;
                            end
                            else if (free_found_reg)
                            begin
                                // allocate the lowest free slot
                                mem_we          = 1'b1;
                                mem_waddr       = free_idx_reg;
                                used_count_next = used_count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                res_status_next = kvt_pkg::ST_FULL;
                            end
                        end

                        kvt_pkg::ACT_DELETE:
                        begin
                            if (hit_found_reg)
                            begin
                                mem_we          = 1'b1;
                                mem_waddr       = hit_idx_reg;
                                mem_wdata       = '0;
                                used_count_next = used_count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                res_status_next = kvt_pkg::ST_NOT_FOUND;
                            end
                        end

                        kvt_pkg::ACT_GET:
                        begin
                            if (hit_found_reg)
                            begin
                                res_value_next = 64'(hit_value_reg);
                                res_len_next   = hit_vlen_reg;
                            end
                            else
                            begin
                                res_status_next = kvt_pkg::ST_NOT_FOUND;
                            end
                        end

                        default:
                        begin
                            res_status_next = kvt_pkg::ST_MALFORMED;
                        end
                    endcase
                end
            end

            kvt_pkg::S_RESULT:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.status      = res_status_reg;
                    rsp_next.read_value  = res_value_reg;
                    rsp_next.read_len    = res_len_reg;
                    rsp_next.entry_count = 7'(used_count_reg);
                    rsp_valid_next       = 1'b1;
                    state_next           = kvt_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = kvt_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kvt_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg      <= kvt_pkg::LIMIT_RESET;
            used_count_reg <= '0;
            idx_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            rd_idx_reg     <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            malformed_reg  <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            limit_reg      <= limit_next;
            used_count_reg <= used_count_next;
            idx_reg        <= idx_next;
            rd_pend_reg    <= rd_pend_next;
            rd_idx_reg     <= rd_idx_next;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            malformed_reg  <= malformed_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        hit_idx_reg    <= hit_idx_next;
        hit_vlen_reg   <= hit_vlen_next;
        hit_value_reg  <= hit_value_next;
        free_idx_reg   <= free_idx_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_len_reg    <= res_len_next;
        rsp_reg        <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== verif/tb_key_value_table_cas.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_value_table_cas: self-checking bench for the key/value table
// Drives put, delete, compare-and-swap and get transactions through the
// valid/stall request channel. A local table model predicts every response.
// The run covers directed corner cases and then random phases under
// several table limits and idling patterns, including a long response hold.
// ----------------------------------------------------------------------------
module tb_key_value_table_cas;

    localparam int TB_ENTRIES     = 64;
    localparam int TB_KEY_BYTES   = 8;
    localparam int TB_VALUE_BYTES = 8;

    // Two copies of the table model: one advanced while stimulus is built,
    // so compare-and-swap can aim at the value the key will hold; one
    // advanced on each accepted transaction, which produces the expectations.
    localparam int SIDE_GEN = 0;
    localparam int SIDE_CHK = 1;

    localparam int HOLD_CYCLES    = 400;   // long response hold-off
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transaction at all
    localparam int SETTLE_CYCLES  = 100;   // above the worst scan latency
    localparam int POOL_MAX       = 96;
    localparam int REPORT_LIMIT   = 10;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    kvt_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    kvt_pkg::rsp_t rsp;
    logic       cfg_we    = 1'b0;
    logic [6:0] cfg_wdata = '0;

    // Stimulus and expectation stores
    kvt_pkg::req_t pending_reqs[$];
    kvt_pkg::rsp_t awaited_rsps[$];
    logic req_taken = 1'b0;

    // Idling knobs, set by the sequencing initial block; hold_count advances in the stall driver
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    logic hold_start    = 1'b0;
    int   hold_count    = 0;

    int fail_count   = 0;
    int quiet_cycles = 0;

    // Table model state, indexed by side then slot
    logic [63:0] tbl_key   [0:1][0:TB_ENTRIES-1];
    logic [3:0]  tbl_klen  [0:1][0:TB_ENTRIES-1];
    logic [63:0] tbl_val   [0:1][0:TB_ENTRIES-1];
    logic [3:0]  tbl_vlen  [0:1][0:TB_ENTRIES-1];
    logic        tbl_used  [0:1][0:TB_ENTRIES-1];
    logic [6:0]  tbl_count [0:1];
    logic [6:0]  tbl_limit [0:1];

    // Key pool for random traffic
    logic [63:0] pool_key [0:POOL_MAX-1];
    logic [3:0]  pool_len [0:POOL_MAX-1];

    key_value_table_cas #(
        .ENTRIES     (TB_ENTRIES),
        .KEY_BYTES   (TB_KEY_BYTES),
        .VALUE_BYTES (TB_VALUE_BYTES)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Table model
    // ------------------------------------------------------------------------

    // Mask of the low len bytes; lengths of 8 and up keep the whole word.
    function automatic logic [63:0] keep_bytes(input logic [3:0] len);
        if (len >= 4'd8)
            return {64{1'b1}};
        return (64'd1 << (8 * len)) - 64'd1;
    endfunction

    // Slots searched and allocated: the limit, clipped to the table size.
    function automatic int active_slots(input int side);
        if (tbl_limit[side] > TB_ENTRIES)
            return TB_ENTRIES;
        return int'(tbl_limit[side]);
    endfunction

    function automatic int find_key(input int side, input logic [63:0] k,
                                    input logic [3:0] kl);
        for (int i = 0; i < active_slots(side); i++)
        begin
            if (tbl_used[side][i] && tbl_klen[side][i] == kl && tbl_key[side][i] == k)
                return i;
        end
        return -1;
    endfunction

    // Overwrite the hit slot, or claim the lowest free one within the limit.
    function automatic kvt_pkg::status_t store_value(input int side, input int hit,
                                                     input logic [63:0] k,
                                                     input logic [3:0] kl,
                                                     input logic [63:0] v,
                                                     input logic [3:0] vl);
        int s;
        s = hit;
        if (s < 0)
        begin
            for (int i = active_slots(side) - 1; i >= 0; i--)
            begin
                if (!tbl_used[side][i])
                    s = i;
            end
            if (s < 0)
                return kvt_pkg::ST_FULL;
            tbl_key[side][s]  = k;
            tbl_klen[side][s] = kl;
            tbl_used[side][s] = 1'b1;
            tbl_count[side]   = tbl_count[side] + 7'd1;
        end
        tbl_val[side][s]  = v;
        tbl_vlen[side][s] = vl;
        return kvt_pkg::ST_OK;
    endfunction

    function automatic void table_reset(input int side);
        for (int i = 0; i < TB_ENTRIES; i++)
        begin
            tbl_key[side][i]  = '0;
            tbl_klen[side][i] = '0;
            tbl_val[side][i]  = '0;
            tbl_vlen[side][i] = '0;
            tbl_used[side][i] = 1'b0;
        end
        tbl_count[side] = '0;
        tbl_limit[side] = kvt_pkg::LIMIT_RESET;
    endfunction

    // Apply one request to one copy of the table and return its response.
    function automatic kvt_pkg::rsp_t table_apply(input int side, input kvt_pkg::req_t r);
        kvt_pkg::rsp_t o;
        logic [63:0]   k, v, e, cur;
        logic [3:0]    cur_len;
        int            hit;
        logic          malformed;
        k = r.key & keep_bytes(r.key_len);
        v = r.new_value & keep_bytes(r.value_len);
        e = r.expected_value & keep_bytes(r.expected_len);
        o = '0;
        o.status = kvt_pkg::ST_OK;
        malformed = (r.key_len == 4'd0) || (r.key_len > TB_KEY_BYTES) ||
                    ((r.action == kvt_pkg::ACT_PUT || r.action == kvt_pkg::ACT_CAS) &&
                     r.value_len > TB_VALUE_BYTES) ||
                    (r.action == kvt_pkg::ACT_CAS && r.expected_len > TB_VALUE_BYTES);
        if (malformed)
            o.status = kvt_pkg::ST_MALFORMED;
        else
        begin
            hit = find_key(side, k, r.key_len);
            case (r.action)
                kvt_pkg::ACT_PUT:
                    o.status = store_value(side, hit, k, r.key_len, v, r.value_len);
                kvt_pkg::ACT_DELETE:
                    if (hit < 0)
                        o.status = kvt_pkg::ST_NOT_FOUND;
                    else
                    begin
                        tbl_used[side][hit] = 1'b0;
                        tbl_count[side]     = tbl_count[side] - 7'd1;
                    end
                kvt_pkg::ACT_CAS:
                begin
                    // An absent key reads as an empty value.
                    cur     = '0;
                    cur_len = '0;
                    if (hit >= 0)
                    begin
                        cur     = tbl_val[side][hit];
                        cur_len = tbl_vlen[side][hit];
                    end
                    if (cur_len != r.expected_len || cur != e)
                        o.status = kvt_pkg::ST_MISMATCH;
                    else
                        o.status = store_value(side, hit, k, r.key_len, v, r.value_len);
                end
                default:
                    if (hit < 0)
                        o.status = kvt_pkg::ST_NOT_FOUND;
                    else
                    begin
                        o.read_value = tbl_val[side][hit];
                        o.read_len   = tbl_vlen[side][hit];
                    end
            endcase
        end
        o.entry_count = tbl_count[side];
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Queue one transaction and advance the stimulus-side model with it.
    task automatic queue_request(input kvt_pkg::req_t r);
        pending_reqs.push_back(r);
        void'(table_apply(SIDE_GEN, r));
    endtask

    task automatic queue_fields(input kvt_pkg::action_t act, input logic [63:0] k,
                                input logic [3:0] kl, input logic [63:0] v,
                                input logic [3:0] vl, input logic [63:0] e,
                                input logic [3:0] el);
        kvt_pkg::req_t r;
        r.action         = act;
        r.key            = k;
        r.key_len        = kl;
        r.new_value      = v;
        r.value_len      = vl;
        r.expected_value = e;
        r.expected_len   = el;
        queue_request(r);
    endtask

    // Random transaction on a key from the first pool_n pool entries. Bytes
    // past each length carry junk so the masking is exercised on every field.
    task automatic queue_random(input int pool_n);
        kvt_pkg::req_t r;
        int            pick, roll, hit;
        logic [63:0]   cur;
        logic [3:0]    cur_len;
        pick      = $urandom_range(0, pool_n - 1);
        r.key     = pool_key[pick] | ({$urandom, $urandom} & ~keep_bytes(pool_len[pick]));
        r.key_len = pool_len[pick];
        roll = $urandom_range(0, 99);
        if (roll < 35)
            r.action = kvt_pkg::ACT_PUT;
        else if (roll < 50)
            r.action = kvt_pkg::ACT_DELETE;
        else if (roll < 75)
            r.action = kvt_pkg::ACT_CAS;
        else
            r.action = kvt_pkg::ACT_GET;
        r.new_value      = {$urandom, $urandom};
        r.value_len      = 4'($urandom_range(0, 8));
        r.expected_value = {$urandom, $urandom};
        r.expected_len   = 4'($urandom_range(0, 8));
        // Aim most compare-and-swap transactions at the value the key will
        // hold when it arrives, so the swap path is taken often.
        if (r.action == kvt_pkg::ACT_CAS && $urandom_range(0, 99) < 65)
        begin
            hit     = find_key(SIDE_GEN, pool_key[pick], pool_len[pick]);
            cur     = '0;
            cur_len = '0;
            if (hit >= 0)
            begin
                cur     = tbl_val[SIDE_GEN][hit];
                cur_len = tbl_vlen[SIDE_GEN][hit];
            end
            r.expected_len   = cur_len;
            r.expected_value = cur | (r.expected_value & ~keep_bytes(cur_len));
        end
        // A little noise: malformed lengths.
        roll = $urandom_range(0, 99);
        if (roll < 2)
            r.key_len = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
        else if (roll < 4)
            r.value_len = 4'($urandom_range(9, 15));
        else if (roll < 6)
            r.expected_len = 4'($urandom_range(9, 15));
        queue_request(r);
    endtask

    // Wait until nothing is queued, offered or awaited. Sample at the rising
    // edge, where the driver's last update has settled.
    task automatic wait_drained;
        @(posedge clk);
        while (pending_reqs.size() != 0 || req_valid || awaited_rsps.size() != 0)
            @(posedge clk);
    endtask

    // Drain, write the limit while the block is idle, set the idling pattern
    // and queue the phase's random transactions.
    task automatic run_phase(input logic [6:0] limit, input int send_pct,
                             input int rcv_pct, input int items, input int pool_n);
        wait_drained();
        repeat (8) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= limit;
        @(negedge clk);
        cfg_we <= 1'b0;
        tbl_limit[SIDE_GEN] = limit;
        send_idle_pct = send_pct;
        stall_pct     = rcv_pct;
        repeat (items) queue_random(pool_n);
    endtask

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("[%0t] %s", $time, what);
    endtask

    // ------------------------------------------------------------------------
    // Request driver: advance on the falling edge. Hold an offered
    // transaction until it is taken; then offer the next one, or idle.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_requests
        if (rst_n && (!req_valid || req_taken))
        begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                req       <= pending_reqs.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Response stall: hold off for a long stretch once asked, counted here;
    // otherwise stall at random.
    always @(negedge clk)
    begin : drive_rsp_stall
        if (hold_start && hold_count < HOLD_CYCLES)
        begin
            rsp_stall  <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: sample on the rising edge. Track limit writes, predict each
    // accepted request, and compare each accepted response with the oldest
    // expectation.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_responses
        kvt_pkg::rsp_t want;
        req_taken <= req_valid && !req_stall;
        if (rst_n)
        begin
            if (cfg_we)
                tbl_limit[SIDE_CHK] = cfg_wdata;
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_rsps.size() == 0)
                    note_failure($sformatf("unexpected response: status %0d count %0d",
                                           rsp.status, rsp.entry_count));
                else
                begin
                    want = awaited_rsps.pop_front();
                    if (rsp.status !== want.status)
                        note_failure($sformatf("status: expected %0d, got %0d",
                                               want.status, rsp.status));
                    if (rsp.read_value !== want.read_value)
                        note_failure($sformatf("read_value: expected %h, got %h",
                                               want.read_value, rsp.read_value));
                    if (rsp.read_len !== want.read_len)
                        note_failure($sformatf("read_len: expected %0d, got %0d",
                                               want.read_len, rsp.read_len));
                    if (rsp.entry_count !== want.entry_count)
                        note_failure($sformatf("entry_count: expected %0d, got %0d",
                                               want.entry_count, rsp.entry_count));
                end
            end
            if (req_valid && !req_stall)
                awaited_rsps.push_back(table_apply(SIDE_CHK, req));
        end
    end

    // Watchdog: count cycles with no transaction on any port.
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed cases, then random phases
    // ------------------------------------------------------------------------
    initial
    begin
        table_reset(SIDE_GEN);
        table_reset(SIDE_CHK);
        for (int i = 0; i < POOL_MAX; i++)
        begin
            pool_len[i] = 4'($urandom_range(1, 8));
            pool_key[i] = {$urandom, $urandom} & keep_bytes(pool_len[i]);
        end

        // Hold reset, then release it; the block then runs its clearing pass
        // with req_stall high, which the driver simply waits out.
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset limit, no idling.
        // Empty table: get and delete miss.
        queue_fields(kvt_pkg::ACT_GET,    64'h1, 4'd1, 64'h0, 4'd0, 64'h0, 4'd0);
        queue_fields(kvt_pkg::ACT_DELETE, 64'h1, 4'd1, 64'h0, 4'd0, 64'h0, 4'd0);
        // One-byte zero key under junk upper bytes; empty value.
        queue_fields(kvt_pkg::ACT_PUT, 64'hDEAD_BEEF_0BAD_F000, 4'd1, {64{1'b1}}, 4'd0,
                     64'h0, 4'd0);
        queue_fields(kvt_pkg::ACT_GET, 64'h0, 4'd1, 64'h0, 4'd0, 64'h0, 4'd0);
        // Full-width key and value, then overwrite with a shorter value.
        queue_fields(kvt_pkg::ACT_PUT, {64{1'b1}}, 4'd8, {64{1'b1}}, 4'd8, 64'h0, 4'd0);
        queue_fields(kvt_pkg::ACT_GET, {64{1'b1}}, 4'd8, 64'h0, 4'd0, 64'h0, 4'd0);
        queue_fields(kvt_pkg::ACT_PUT, {64{1'b1}}, 4'd8, 64'h1234_5678_9ABC_DEF0, 4'd3,
                     64'h0, 4'd0);
        queue_fields(kvt_pkg::ACT_GET, {64{1'b1}}, 4'd8, 64'h0, 4'd0, 64'h0, 4'd0);
        // Compare-and-swap: match, then mismatch on length alone.
        queue_fields(kvt_pkg::ACT_CAS, {64{1'b1}}, 4'd8, 64'h0, 4'd8,
                     64'hFFFF_FFFF_FFBC_DEF0, 4'd3);
        queue_fields(kvt_pkg::ACT_CAS, {64{1'b1}}, 4'd8, 64'h7, 4'd1, 64'h0, 4'd3);
        // Compare-and-swap on an absent key: empty expectation inserts,
        // anything else mismatches.
        queue_fields(kvt_pkg::ACT_CAS, 64'hAA, 4'd2, 64'h55, 4'd1, 64'hFFFF, 4'd0);
        queue_fields(kvt_pkg::ACT_CAS, 64'hBB, 4'd2, 64'h55, 4'd1, 64'h0, 4'd2);
        queue_fields(kvt_pkg::ACT_DELETE, {64{1'b1}}, 4'd8, 64'h0, 4'd0, 64'h0, 4'd0);
        queue_fields(kvt_pkg::ACT_GET,    {64{1'b1}}, 4'd8, 64'h0, 4'd0, 64'h0, 4'd0);
        // Malformed lengths on every action.
        queue_fields(kvt_pkg::ACT_PUT,    64'h5, 4'd0,  64'h1, 4'd1,  64'h0, 4'd0);
        queue_fields(kvt_pkg::ACT_GET,    64'h5, 4'd9,  64'h0, 4'd0,  64'h0, 4'd0);
        queue_fields(kvt_pkg::ACT_DELETE, 64'h5, 4'd15, 64'h0, 4'd0,  64'h0, 4'd0);
        queue_fields(kvt_pkg::ACT_PUT,    64'h5, 4'd1,  64'h1, 4'd9,  64'h0, 4'd0);
        queue_fields(kvt_pkg::ACT_CAS,    64'h5, 4'd1,  64'h1, 4'd1,  64'h0, 4'd15);
        queue_fields(kvt_pkg::ACT_CAS,    64'h5, 4'd1,  64'h1, 4'd12, 64'h0, 4'd0);
        // Value lengths are ignored by get.
        queue_fields(kvt_pkg::ACT_GET, 64'h0, 4'd1, 64'h0, 4'd15, 64'h0, 4'd15);
        // Same bytes, different length: a separate key.
        queue_fields(kvt_pkg::ACT_PUT,    64'h0, 4'd2, 64'hCAFE, 4'd2, 64'h0, 4'd0);
        queue_fields(kvt_pkg::ACT_GET,    64'h0, 4'd8, 64'h0,    4'd0, 64'h0, 4'd0);
        queue_fields(kvt_pkg::ACT_DELETE, 64'h0, 4'd1, 64'h0,    4'd0, 64'h0, 4'd0);

        // Random phases. Start with a long response hold while the sender
        // keeps offering, so the block fills and stalls its request side.
        run_phase(7'd64, 0, 0, 300, 24);
        hold_start <= 1'b1;
        // Lowered limit: slots above it stay counted but are not searched.
        run_phase(7'd8,   58, 0,  250, 24);
        run_phase(7'd1,   0,  58, 150, 6);
        run_phase(7'd0,   36, 36, 60,  8);
        // Large key pools drive the table to full at the top limits.
        run_phase(7'd127, 0,  0,  350, 96);
        run_phase(7'd100, 58, 0,  200, 96);
        run_phase(7'd4,   0,  58, 200, 12);
        run_phase(7'd64,  36, 36, 200, 40);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (awaited_rsps.size() != 0)
            note_failure($sformatf("%0d responses never arrived", awaited_rsps.size()));
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/kvt_pkg.sv
rtl/core/kvt_slot_ram.sv
rtl/core/key_value_table_cas.sv
verif/tb_key_value_table_cas.sv
